// ===== rtl/core/llsk_pkg.sv =====
// Package: shared types and constants for the loglog sketch update block.
package llsk_pkg;
    localparam int KEY_W = 64;
    localparam int SEED_W = 32;
    localparam int RANK_W = 7;
    localparam int SUM_W = 17;
    localparam int ZCNT_W = 11;
    localparam int IDXF_W = 10;
    localparam logic [RANK_W-1:0] MAX_RANK = 7'd64;
    localparam logic [RANK_W-1:0] RANK_LIMIT_RST = 7'd32;
    localparam logic [63:0] HASH_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] HASH_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic CFG_SEED = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] w0;
        logic [KEY_W-1:0] w1;
    } hash_pair_t;
endpackage

// ===== rtl/core/llsk_if.sv =====
// Interfaces: valid/ready channels for items, results and configuration.
interface llsk_in_if;
    import llsk_pkg::*;
    logic valid;
    logic ready;
    logic command;
    logic [KEY_W-1:0] key;
    modport source (output valid, command, key, input ready);
    modport sink (input valid, command, key, output ready);
endinterface

interface llsk_out_if;
    import llsk_pkg::*;
    logic valid;
    logic ready;
    logic [IDXF_W-1:0] bucket_index;
    logic [RANK_W-1:0] bucket_value;
    logic [SUM_W-1:0] register_sum;
    logic [ZCNT_W-1:0] zero_count;
    modport source (output valid, bucket_index, bucket_value, register_sum, zero_count,
                    input ready);
    modport sink (input valid, bucket_index, bucket_value, register_sum, zero_count,
                  output ready);
endinterface

interface llsk_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/llsk_ram.sv =====
// Generic RAM with one write port and one read port, registered read.
module llsk_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/llsk_mul64.sv =====
// Multi-cycle 64x64 low-half multiplier, one 32x32 product per cycle.
module llsk_mul64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);
    logic [2:0]  step_reg;
    logic [63:0] acc_reg;
    logic [63:0] a_reg, b_reg;
    logic [31:0] x, y;
    logic [63:0] prod_reg;
    logic        busy_reg;

    always_comb
    begin
        case (step_reg)
            3'd0: begin x = a_reg[31:0];  y = b_reg[31:0];  end
            3'd1: begin x = a_reg[31:0];  y = b_reg[63:32]; end
            default: begin x = a_reg[63:32]; y = b_reg[31:0]; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= {32'd0, x} * {32'd0, y};
            case (step_reg)
                3'd1: acc_reg <= acc_reg + prod_reg;
                3'd2: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                3'd3: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    assign p = acc_reg;
endmodule

// ===== rtl/core/llsk_hash.sv =====
// Sequential MurmurHash3 x64 128 of one 8-byte key on a shared multiplier.
module llsk_hash
    import llsk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [31:0] seed,
    output logic        done,
    output hash_pair_t  result
);
    localparam logic [3:0] H_IDLE = 4'd0;
    localparam logic [3:0] H_K1   = 4'd1;
    localparam logic [3:0] H_K2   = 4'd2;
    localparam logic [3:0] H_A1   = 4'd3;
    localparam logic [3:0] H_A2   = 4'd4;
    localparam logic [3:0] H_B1   = 4'd5;
    localparam logic [3:0] H_B2   = 4'd6;
    localparam logic [3:0] H_FIN  = 4'd7;

    logic [3:0]  st_reg;
    logic        wait_reg;
    logic [63:0] a_reg, b_reg, k_reg;
    logic        m_start, m_done;
    logic [63:0] m_a, m_b, m_p;

    llsk_mul64 u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
        .done(m_done), .p(m_p)
    );

    always_comb
    begin
        m_a = k_reg;
        m_b = HASH_C1;
        case (st_reg)
            H_K1: begin m_a = k_reg; m_b = HASH_C1; end
            H_K2: begin m_a = k_reg; m_b = HASH_C2; end
            H_A1, H_B1: begin m_a = k_reg; m_b = FMIX_C1; end
            H_A2, H_B2: begin m_a = k_reg; m_b = FMIX_C2; end
            default: begin m_a = k_reg; m_b = HASH_C1; end
        endcase
    end

    assign m_start = (st_reg != H_IDLE) && (st_reg != H_FIN) && !wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= H_IDLE;
            wait_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (m_start)
            begin
                wait_reg <= 1'b1;
            end
            case (st_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= H_K1;
                    end
                end
                H_FIN:
                begin
                    done   <= 1'b1;
                    st_reg <= H_IDLE;
                end
                default:
                begin
                    if (m_done)
                    begin
                        wait_reg <= 1'b0;
                        st_reg   <= st_reg + 4'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == H_IDLE && start)
        begin
            k_reg <= key;
            a_reg <= {32'd0, seed};
            b_reg <= {32'd0, seed};
        end
        else if (m_done)
        begin
            case (st_reg)
                H_K1: k_reg <= {m_p[32:0], m_p[63:33]};
                H_K2:
                begin
                    // a ^= k, xor in length, cross-add, then start mix of a
                    k_reg <= ((a_reg ^ m_p ^ 64'd8) + (b_reg ^ 64'd8))
                           ^ (((a_reg ^ m_p ^ 64'd8) + (b_reg ^ 64'd8)) >> 33);
                    a_reg <= (a_reg ^ m_p ^ 64'd8) + (b_reg ^ 64'd8);
                    b_reg <= (b_reg ^ 64'd8) + ((a_reg ^ m_p ^ 64'd8) + (b_reg ^ 64'd8));
                end
                H_A1: k_reg <= m_p ^ (m_p >> 33);
                H_A2:
                begin
                    a_reg <= m_p ^ (m_p >> 33);
                    k_reg <= b_reg ^ (b_reg >> 33);
                end
                H_B1: k_reg <= m_p ^ (m_p >> 33);
                H_B2: b_reg <= m_p ^ (m_p >> 33);
                default: k_reg <= k_reg;
            endcase
        end
    end

    assign result.w0 = a_reg + b_reg;
    assign result.w1 = b_reg + (a_reg + b_reg);
endmodule

// ===== rtl/core/loglog_sketch_update.sv =====
// Top level: loglog sketch update with bucket store in a synchronous RAM.
// Results: an insert result follows six 64-bit multiplies on one 32x32
// multiplier, then hash finish, RAM read and write-back; a clear result is
// valid the next cycle.
// Items: one at a time; an item is taken only in idle with no result pending,
// and a clear returns to idle after sweeping all 2^INDEX_BITS bucket RAM entries.
// Reset: a clearing pass over 2^INDEX_BITS entries follows reset, during
// which no item is accepted; config resets to seed 0, rank limit 32.
module loglog_sketch_update
    import llsk_pkg::*;
#(
    parameter int INDEX_BITS = 10
) (
    input logic clk,
    input logic rst_n,
    llsk_in_if.sink   in_ch,
    llsk_out_if.source out_ch,
    llsk_cfg_if.sink  cfg
);
    localparam int NB = 1 << INDEX_BITS;
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            st_reg;
    logic [INDEX_BITS:0]   clr_reg;
    logic [31:0]           seed_reg;
    logic [RANK_W-1:0]     limit_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [ZCNT_W-1:0]     zcnt_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [RANK_W-1:0]     val_reg;
    logic                  h_start, h_done;
    hash_pair_t            h_res;
    logic                  ram_we;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic [RANK_W-1:0]     ram_wdata, ram_rdata;
    logic [RANK_W-1:0]     cap, tz_rank;

    assign cfg.ready = 1'b1;
    // Hold input while a clear result still waits on the output.
    assign in_ch.ready = (st_reg == S_IDLE) && !out_ch.valid;
    assign h_start = in_ch.valid && in_ch.ready && (in_ch.command == CMD_INSERT);

    llsk_hash u_hash (
        .clk(clk), .rst_n(rst_n), .start(h_start), .key(in_ch.key),
        .seed(seed_reg), .done(h_done), .result(h_res)
    );

    llsk_ram #(.WIDTH(RANK_W), .DEPTH(NB)) u_store (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(idx_reg), .rdata(ram_rdata)
    );

    // Trailing zeros plus one; all-zero word ranks 65, the cap pulls it down.
    always_comb
    begin
        tz_rank = 7'd65;
        for (int i = 63; i >= 0; i--)
        begin
            if (h_res.w1[i])
            begin
                tz_rank = 7'(i + 1);
            end
        end
        cap = (limit_reg > MAX_RANK) ? MAX_RANK : limit_reg;
    end

    assign ram_we    = (st_reg == S_CLEAR) || (st_reg == S_WRITE && rank_reg > ram_rdata);
    assign ram_waddr = (st_reg == S_CLEAR) ? clr_reg[INDEX_BITS-1:0] : idx_reg;
    assign ram_wdata = (st_reg == S_CLEAR) ? '0 : rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_CLEAR;
            clr_reg   <= '0;
            seed_reg  <= '0;
            limit_reg <= RANK_LIMIT_RST;
            sum_reg   <= '0;
            zcnt_reg  <= ZCNT_W'(NB);
            out_ch.valid <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_SEED)
                begin
                    seed_reg <= cfg.data;
                end
                else
                begin
                    limit_reg <= cfg.data[RANK_W-1:0];
                end
            end
            case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (INDEX_BITS+1)'(1);
                    if (clr_reg == (INDEX_BITS+1)'(NB - 1))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (out_ch.valid)
                    begin
                        // Clear result outlived the sweep; drop it once taken.
                        if (out_ch.ready)
                        begin
                            out_ch.valid <= 1'b0;
                        end
                    end
                    else if (in_ch.valid)
                    begin
                        if (in_ch.command == CMD_CLEAR)
                        begin
                            // Report cleared state, then sweep the store.
                            clr_reg      <= '0;
                            sum_reg      <= '0;
                            zcnt_reg     <= ZCNT_W'(NB);
                            idx_reg      <= '0;
                            val_reg      <= '0;
                            out_ch.valid <= 1'b1;
                            st_reg       <= S_CLEAR;
                        end
                        else
                        begin
                            st_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    if (h_done)
                    begin
                        idx_reg  <= h_res.w0[63 -: INDEX_BITS];
                        rank_reg <= (tz_rank > cap) ? cap : tz_rank;
                        st_reg   <= S_READ;
                    end
                end
                S_READ: st_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (rank_reg > ram_rdata)
                    begin
                        val_reg <= rank_reg;
                        sum_reg <= sum_reg + SUM_W'(rank_reg - ram_rdata);
                        if (ram_rdata == '0 && zcnt_reg != '0)
                        begin
                            zcnt_reg <= zcnt_reg - ZCNT_W'(1);
                        end
                    end
                    else
                    begin
                        val_reg <= ram_rdata;
                    end
                    out_ch.valid <= 1'b1;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        out_ch.valid <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            // Drop the clear result once taken (sweep runs meanwhile).
            if (st_reg == S_CLEAR && out_ch.valid && out_ch.ready)
            begin
                out_ch.valid <= 1'b0;
            end
        end
    end

    // Result fields come straight from the held registers.
    assign out_ch.bucket_index = IDXF_W'(idx_reg);
    assign out_ch.bucket_value = val_reg;
    assign out_ch.register_sum = sum_reg;
    assign out_ch.zero_count   = zcnt_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid || st_reg == S_IDLE)
        else $error("ready while busy");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        zcnt_reg <= ZCNT_W'(NB))
        else $error("zero count above bucket count");
    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && st_reg == S_WRITE) |-> rank_reg > ram_rdata)
        else $error("write does not raise bucket");
`endif
endmodule
